### rtl/core/cfd_pkg.sv
// Shared types and constants of the command frame deframer.
package cfd_pkg;

    // Frame framing bytes and sizes
    localparam logic [7:0]  START_MARK = 8'h2B;
    localparam logic [7:0]  END_MARK   = 8'hB2;
    localparam int unsigned OVERHEAD   = 9;
    localparam logic [15:0] CMD_TYPE   = 16'h0003;

    // Frame offsets of the header fields
    localparam int unsigned POS_LEN_LO = 2;
    localparam int unsigned POS_LEN_HI = 3;
    localparam int unsigned POS_KND_LO = 4;
    localparam int unsigned POS_KND_HI = 5;
    localparam int unsigned POS_BODY   = 6;

    // Command codes of a command-type frame
    localparam logic [7:0] CMD_READ_IMU  = 8'h03;
    localparam logic [7:0] CMD_WRITE_IMU = 8'h04;
    localparam logic [7:0] CMD_READ_NV   = 8'h05;
    localparam logic [7:0] CMD_WRITE_NV  = 8'h06;
    localparam logic [7:0] CMD_READ_VER  = 8'h07;

    typedef enum logic [2:0] {
        ST_WAIT        = 3'd0,
        ST_BAD_START   = 3'd1,
        ST_OVERFLOW    = 3'd2,
        ST_BAD_TRAILER = 3'd3,
        ST_BAD_SUM     = 3'd4,
        ST_ACCEPT      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_READ_IMU  = 3'd1,
        ACT_WRITE_IMU = 3'd2,
        ACT_READ_NV   = 3'd3,
        ACT_WRITE_NV  = 3'd4,
        ACT_READ_VER  = 3'd5
    } t_action;

    // Header fields and checksum state of the frame being assembled
    typedef struct packed {
        logic [15:0] length_word;
        logic [15:0] kind_word;
        logic [7:0]  command_byte;
        logic [7:0]  running_sum;
        logic [7:0]  tail0;
        logic [7:0]  tail1;
        logic [7:0]  tail2;
    } t_frame_fields;

    // One reported result
    typedef struct packed {
        t_status     status;
        logic [15:0] frame_kind;
        logic [7:0]  command;
        t_action     action;
        logic [8:0]  body_length;
    } t_result;

endpackage

### rtl/core/cfd_byte_if.sv
// Byte channel: one received chunk byte with its chunk marks.
interface cfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_first;
    logic       chunk_last;

    modport source (output valid, output data_byte, output chunk_first,
                    output chunk_last, input ready);
    modport sink   (input valid, input data_byte, input chunk_first,
                    input chunk_last, output ready);
endinterface

### rtl/core/cfd_result_if.sv
// Result channel: one status report per chunk end.
interface cfd_result_if;
    logic                 valid;
    logic                 ready;
    cfd_pkg::t_status     status;
    logic [15:0]          frame_kind;
    logic [7:0]           command;
    cfd_pkg::t_action     action;
    logic [8:0]           body_length;

    modport source (output valid, output status, output frame_kind, output command,
                    output action, output body_length, input ready);
    modport sink   (input valid, input status, input frame_kind, input command,
                    input action, input body_length, output ready);
endinterface

### rtl/core/cfd_check.sv
// Chunk-end frame judgement: status, decoded fields and frame clear.
module cfd_check #(
    parameter int BUF_LEN = 512,
    parameter int FILL_W  = 10
) (
    input  logic [FILL_W-1:0]   i_fill,
    input  logic                i_start_ok,
    input  cfd_pkg::t_frame_fields i_fields,
    output cfd_pkg::t_result    o_result,
    output logic                o_clear
);
    import cfd_pkg::*;

    logic [7:0]  body_sum;
    logic [15:0] fill_ext;
    logic        len_match;

    // Checksum excludes the checksum byte and the two trailer bytes
    assign body_sum  = i_fields.running_sum - i_fields.tail0 - i_fields.tail1
                       - i_fields.tail2;
    assign fill_ext  = 16'(i_fill);
    assign len_match = (i_fill > FILL_W'(OVERHEAD)) &&
                       (i_fields.length_word == fill_ext - 16'(OVERHEAD));

    always_comb begin
        o_result = '{status: ST_WAIT, frame_kind: 16'd0, command: 8'd0,
                     action: ACT_NONE, body_length: 9'd0};
        o_clear  = 1'b0;
        if (!i_start_ok || (i_fill < FILL_W'(2))) begin
            o_result.status = ST_BAD_START;
            o_clear         = 1'b1;
        end else if (i_fill > FILL_W'(BUF_LEN - 1)) begin
            o_result.status = ST_OVERFLOW;
            o_clear         = 1'b1;
        end else if (len_match) begin
            o_clear = 1'b1;
            if ((i_fields.tail0 != END_MARK) || (i_fields.tail1 != END_MARK)) begin
                o_result.status = ST_BAD_TRAILER;
            end else if (body_sum != i_fields.tail2) begin
                o_result.status = ST_BAD_SUM;
            end else begin
                o_result.status      = ST_ACCEPT;
                o_result.frame_kind  = i_fields.kind_word;
                o_result.command     = i_fields.command_byte;
                o_result.body_length = i_fields.length_word[8:0];
                if (i_fields.kind_word == CMD_TYPE) begin
                    case (i_fields.command_byte)
                        CMD_READ_IMU:  o_result.action = ACT_READ_IMU;
                        CMD_WRITE_IMU: o_result.action = ACT_WRITE_IMU;
                        CMD_READ_NV:   o_result.action = ACT_READ_NV;
                        CMD_WRITE_NV:  o_result.action = ACT_WRITE_NV;
                        CMD_READ_VER:  o_result.action = ACT_READ_VER;
                        default:       o_result.action = ACT_NONE;
                    endcase
                end
            end
        end
    end

endmodule

### rtl/core/command_frame_deframer_core.sv
// Top level of the command frame deframer.
// Reassembles 0x2B 0x2B / length / type / body / checksum / 0xB2 0xB2 frames from
// chunked bytes. Each byte updates the header fields, running checksum and fill
// counter in the same cycle it is accepted, and on the last byte of a chunk the
// judgement is written into a single output register.
// A new byte is taken every cycle unless that output register holds a report
// that the sink has not taken yet; then the input stalls. One report follows
// each chunk end, in the cycle after its last byte. Bytes past CHUNK_MAX in a
// chunk are dropped except for their end mark.
module command_frame_deframer_core #(
    parameter int BUF_LEN   = 512,
    parameter int CHUNK_MAX = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cfd_byte_if.sink     i_byte,
    cfd_result_if.source o_result
);
    import cfd_pkg::*;

    localparam int FILL_W = $clog2(BUF_LEN + 1);
    localparam int OFS_W  = $clog2(CHUNK_MAX + 1);

    logic [FILL_W-1:0] r_fill,     n_fill;
    logic [OFS_W-1:0]  r_offset,   n_offset;
    logic              r_start_ok, n_start_ok;
    t_frame_fields     r_fields,   n_fields;
    logic              r_out_valid;
    t_result           r_out;

    logic [FILL_W-1:0] take_fill;
    logic              take_ok;
    t_frame_fields     take_fields;
    t_result           chk_result;
    logic              chk_clear;
    logic              accept;
    logic              take;
    logic [7:0]        d;

    assign accept = i_byte.valid && i_byte.ready;
    assign take   = accept && (r_offset < OFS_W'(CHUNK_MAX));
    assign d      = i_byte.data_byte;

    // Input stalls only while an untaken report sits in the output register
    assign i_byte.ready = !r_out_valid || o_result.ready;

    // Absorb one byte into the frame
    always_comb begin
        take_fill   = r_fill;
        take_ok     = r_start_ok;
        take_fields = r_fields;
        if (take) begin
            if (r_offset == '0) begin
                take_ok = (r_fill != '0) || (d == START_MARK);
            end else if ((r_offset == OFS_W'(1)) && (r_fill == FILL_W'(1))) begin
                take_ok = r_start_ok && (d == START_MARK);
            end
            case (r_fill)
                FILL_W'(POS_LEN_LO): take_fields.length_word[7:0]  = d;
                FILL_W'(POS_LEN_HI): take_fields.length_word[15:8] = d;
                FILL_W'(POS_KND_LO): take_fields.kind_word[7:0]    = d;
                FILL_W'(POS_KND_HI): take_fields.kind_word[15:8]   = d;
                FILL_W'(POS_BODY):   take_fields.command_byte      = d;
                default: ;
            endcase
            if (r_fill >= FILL_W'(POS_BODY)) begin
                take_fields.running_sum = r_fields.running_sum + d;
                take_fields.tail2       = r_fields.tail1;
                take_fields.tail1       = r_fields.tail0;
                take_fields.tail0       = d;
            end
            if (r_fill < FILL_W'(BUF_LEN)) begin
                take_fill = r_fill + FILL_W'(1);
            end
        end
    end

    cfd_check #(
        .BUF_LEN (BUF_LEN),
        .FILL_W  (FILL_W)
    ) u_check (
        .i_fill     (take_fill),
        .i_start_ok (take_ok),
        .i_fields   (take_fields),
        .o_result   (chk_result),
        .o_clear    (chk_clear)
    );

    // Next frame state, with chunk close and frame clear
    always_comb begin
        n_fill     = take_fill;
        n_start_ok = take_ok;
        n_fields   = take_fields;
        n_offset   = take ? r_offset + OFS_W'(1) : r_offset;
        if (accept && i_byte.chunk_last) begin
            n_offset = '0;
            if (chk_clear) begin
                n_fill   = '0;
                n_fields = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_offset   <= '0;
            r_start_ok <= 1'b0;
            r_fields   <= '0;
        end else begin
            r_fill     <= n_fill;
            r_offset   <= n_offset;
            r_start_ok <= n_start_ok;
            r_fields   <= n_fields;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_byte.chunk_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_byte.chunk_last) begin
            r_out <= chk_result;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out.status;
    assign o_result.frame_kind  = r_out.frame_kind;
    assign o_result.command     = r_out.command;
    assign o_result.action      = r_out.action;
    assign o_result.body_length = r_out.body_length;

    // Counters stay within their limits
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= OFS_W'(CHUNK_MAX))
        else $error("chunk offset past limit");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BUF_LEN))
        else $error("frame fill past limit");

    // Chunk end closes the chunk and raises a report
    a_chunk_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte.chunk_last) |=> (r_offset == '0) && r_out_valid)
        else $error("chunk end not closed or not reported");

    // A clearing verdict empties the frame
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte.chunk_last && chk_clear) |=> (r_fill == '0))
        else $error("frame not cleared");

    // Fields other than status are zero unless the frame is accepted
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_ACCEPT)) |->
        (r_out.frame_kind == 16'd0) && (r_out.command == 8'd0) &&
        (r_out.action == ACT_NONE) && (r_out.body_length == 9'd0))
        else $error("non-accepted report carries fields");

endmodule
